### rtl/wida_pkg.sv
`default_nettype none

package wida_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned DIST_W        = 48;
    localparam int unsigned PROD_W        = 2 * DATA_W;
    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam int unsigned LOG_FRAC      = 28;
    localparam int unsigned LN2_W         = 30;
    localparam int unsigned P_W           = $clog2(DATA_W);

    localparam logic [LN2_W-1:0]  LN2_Q30  = 30'd744261118;
    localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CHECK  = 13'b0000000000010,
        ST_SQUARE = 13'b0000000000100,
        ST_L2     = 13'b0000000001000,
        ST_LNMUL  = 13'b0000000010000,
        ST_AMUL   = 13'b0000000100000,
        ST_BMUL   = 13'b0000001000000,
        ST_MAG    = 13'b0000010000000,
        ST_HIMUL  = 13'b0000100000000,
        ST_LOMUL  = 13'b0001000000000,
        ST_TERM   = 13'b0010000000000,
        ST_ACC    = 13'b0100000000000,
        ST_FINISH = 13'b1000000000000
    } wida_state_t;

    typedef struct packed {
        logic load;
        logic norm;
        logic square;
        logic l2;
        logic lnmul;
        logic amul;
        logic bmul;
        logic mag;
        logic himul;
        logic lomul;
        logic term;
        logic acc;
        logic zsat;
        logic emit;
    } wida_cmd_t;

    typedef struct packed {
        logic proto_zero;
        logic sticky;
        logic last;
        logic out_free;
    } wida_stat_t;

endpackage

`default_nettype wire

### rtl/wida_col_if.sv
`default_nettype none

interface wida_col_if;
    import wida_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] proto_factor;
    logic [DATA_W-1:0] data_value;
    logic [DATA_W-1:0] proto_value;
    logic              last_column;

    modport source (
        output valid, weight, proto_factor, data_value, proto_value, last_column,
        input  ready
    );

    modport sink (
        input  valid, weight, proto_factor, data_value, proto_value, last_column,
        output ready
    );
endinterface

`default_nettype wire

### rtl/wida_res_if.sv
`default_nettype none

interface wida_res_if;
    import wida_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DIST_W-1:0] distance;
    logic                     saturated;

    modport source (
        output valid, distance, saturated,
        input  ready
    );

    modport sink (
        input  valid, distance, saturated,
        output ready
    );
endinterface

`default_nettype wire

### rtl/wida_ctrl.sv
`default_nettype none

module wida_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output wida_pkg::wida_cmd_t cmd,
    input  wida_pkg::wida_stat_t stat
);
    import wida_pkg::*;

    localparam int unsigned CNT_W = $clog2(LOG_FRAC);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOG_FRAC - 1);

    wida_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.sticky)
                begin
                    state_next = ST_FINISH;
                end
                else if (stat.proto_zero)
                begin
                    cmd.zsat   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.norm   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_L2;
                end
            end
            ST_L2:
            begin
                cmd.l2     = 1'b1;
                state_next = ST_LNMUL;
            end
            ST_LNMUL:
            begin
                cmd.lnmul  = 1'b1;
                state_next = ST_AMUL;
            end
            ST_AMUL:
            begin
                cmd.amul   = 1'b1;
                state_next = ST_BMUL;
            end
            ST_BMUL:
            begin
                cmd.bmul   = 1'b1;
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = ST_HIMUL;
            end
            ST_HIMUL:
            begin
                cmd.himul  = 1'b1;
                state_next = ST_LOMUL;
            end
            ST_LOMUL:
            begin
                cmd.lomul  = 1'b1;
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.last)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### rtl/wida_dp.sv
`default_nettype none

module wida_dp #(
    parameter int unsigned FRAC_BITS = wida_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  wida_pkg::wida_cmd_t                     cmd,
    output wida_pkg::wida_stat_t                    stat,
    input  logic [wida_pkg::DATA_W-1:0]             weight,
    input  logic [wida_pkg::DATA_W-1:0]             proto_factor,
    input  logic [wida_pkg::DATA_W-1:0]             data_value,
    input  logic [wida_pkg::DATA_W-1:0]             proto_value,
    input  logic                                    last_column,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [wida_pkg::DIST_W-1:0]      distance,
    output logic                                    saturated
);
    import wida_pkg::*;

    localparam int unsigned LNM_W    = FRAC_BITS + 5;
    localparam int unsigned A_W      = PROD_W - FRAC_BITS;
    localparam int unsigned MAG_W    = A_W + 1;
    localparam int unsigned LN_SH    = LN2_W + LOG_FRAC - FRAC_BITS;
    localparam int unsigned HI_SH    = 15 + FRAC_BITS;
    localparam int unsigned L2_W     = LOG_FRAC + 7;
    localparam int unsigned L2MAG_W  = DATA_W + 1;
    localparam int unsigned EXT_W    = PROD_W - DIST_W;

    logic [DATA_W-1:0]        w_reg, f_reg, d_reg, v_reg;
    logic                     last_reg;
    logic [DATA_W-1:0]        y_reg, y_next;
    logic [P_W-1:0]           p_reg, p_next;
    logic [LOG_FRAC-1:0]      frac_reg, frac_next;
    logic                     lneg_reg, lneg_next;
    logic [L2MAG_W-1:0]       l2mag_reg, l2mag_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [LNM_W-1:0]         lnm_reg, lnm_next;
    logic [A_W-1:0]           a_reg, a_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     ineg_reg, ineg_next;
    logic [PROD_W-1:0]        hiprod_reg, hiprod_next;
    logic [PROD_W-1:0]        tmag_reg, tmag_next;
    logic                     hiovf_reg, hiovf_next;
    logic [DIST_W-1:0]        sum_reg, sum_next;
    logic                     sticky_reg, sticky_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DIST_W-1:0]        dist_reg;
    logic                     sat_reg;

    logic [DATA_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [P_W-1:0]           p_enc;
    logic [DATA_W:0]          sq_hi;
    logic [6:0]               pf;
    logic signed [L2_W-1:0]   l2_s, l2_abs;
    logic [A_W-1:0]           b_val;
    logic signed [PROD_W-1:0] term_s, sum_w;

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.square)
        begin
            mul_a = y_reg;
            mul_b = y_reg;
        end
        else if (cmd.lnmul)
        begin
            mul_a = l2mag_reg[DATA_W-1:0];
            mul_b = DATA_W'(LN2_Q30);
        end
        else if (cmd.amul)
        begin
            mul_a = f_reg;
            mul_b = v_reg;
        end
        else if (cmd.bmul)
        begin
            mul_a = d_reg;
            mul_b = DATA_W'(lnm_reg);
        end
        else if (cmd.himul)
        begin
            mul_a = w_reg;
            mul_b = DATA_W'(mag_reg[MAG_W-1:DATA_W]);
        end
        else if (cmd.lomul)
        begin
            mul_a = w_reg;
            mul_b = mag_reg[DATA_W-1:0];
        end
    end

    always_comb
    begin
        p_enc = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (v_reg[i])
            begin
                p_enc = P_W'(i);
            end
        end
    end

    assign sq_hi  = mul_p[PROD_W-1:DATA_W-1];
    assign pf     = 7'(p_reg) - 7'(FRAC_BITS);
    assign l2_s   = $signed({pf, {LOG_FRAC{1'b0}}}) + $signed({7'd0, frac_reg});
    assign l2_abs = l2_s[L2_W-1] ? -l2_s : l2_s;
    assign b_val  = A_W'(prod_reg >> FRAC_BITS);
    assign term_s = ineg_reg ? -$signed(tmag_reg) : $signed(tmag_reg);
    assign sum_w  = $signed({{EXT_W{sum_reg[DIST_W-1]}}, sum_reg}) + term_s;

    always_comb
    begin
        y_next      = y_reg;
        p_next      = p_reg;
        frac_next   = frac_reg;
        lneg_next   = lneg_reg;
        l2mag_next  = l2mag_reg;
        prod_next   = prod_reg;
        lnm_next    = lnm_reg;
        a_next      = a_reg;
        mag_next    = mag_reg;
        ineg_next   = ineg_reg;
        hiprod_next = hiprod_reg;
        tmag_next   = tmag_reg;
        hiovf_next  = hiovf_reg;
        if (cmd.norm)
        begin
            p_next    = p_enc;
            y_next    = v_reg << (P_W'(DATA_W - 1) - p_enc);
            frac_next = '0;
        end
        if (cmd.square)
        begin
            if (sq_hi[DATA_W])
            begin
                y_next    = sq_hi[DATA_W:1];
                frac_next = {frac_reg[LOG_FRAC-2:0], 1'b1};
            end
            else
            begin
                y_next    = sq_hi[DATA_W-1:0];
                frac_next = {frac_reg[LOG_FRAC-2:0], 1'b0};
            end
        end
        if (cmd.l2)
        begin
            lneg_next  = l2_s[L2_W-1];
            l2mag_next = l2_abs[L2MAG_W-1:0];
        end
        if (cmd.lnmul)
        begin
            prod_next = mul_p + (l2mag_reg[DATA_W] ? (PROD_W'(LN2_Q30) << DATA_W) : '0);
        end
        if (cmd.amul)
        begin
            lnm_next  = LNM_W'(prod_reg >> LN_SH);
            prod_next = mul_p;
        end
        if (cmd.bmul)
        begin
            a_next    = A_W'(prod_reg >> FRAC_BITS);
            prod_next = mul_p;
        end
        if (cmd.mag)
        begin
            if (lneg_reg)
            begin
                mag_next  = MAG_W'(a_reg) + MAG_W'(b_val);
                ineg_next = 1'b0;
            end
            else if (a_reg >= b_val)
            begin
                mag_next  = MAG_W'(a_reg - b_val);
                ineg_next = 1'b0;
            end
            else
            begin
                mag_next  = MAG_W'(b_val - a_reg);
                ineg_next = 1'b1;
            end
        end
        if (cmd.himul)
        begin
            prod_next = mul_p;
        end
        if (cmd.lomul)
        begin
            hiprod_next = prod_reg;
            prod_next   = mul_p;
        end
        if (cmd.term)
        begin
            hiovf_next = hiprod_reg >= (PROD_W'(1) << HI_SH);
            tmag_next  = (hiprod_reg << (DATA_W - FRAC_BITS)) + (prod_reg >> FRAC_BITS);
        end
    end

    always_comb
    begin
        sum_next    = sum_reg;
        sticky_next = sticky_reg;
        if (cmd.zsat)
        begin
            sum_next    = DIST_MAX;
            sticky_next = 1'b1;
        end
        if (cmd.acc)
        begin
            if (hiovf_reg)
            begin
                sum_next    = ineg_reg ? DIST_MIN : DIST_MAX;
                sticky_next = 1'b1;
            end
            else if (sum_w[PROD_W-1:DIST_W-1] != {(EXT_W+1){sum_w[PROD_W-1]}})
            begin
                sum_next    = sum_w[PROD_W-1] ? DIST_MIN : DIST_MAX;
                sticky_next = 1'b1;
            end
            else
            begin
                sum_next = sum_w[DIST_W-1:0];
            end
        end
        if (cmd.emit)
        begin
            sum_next    = '0;
            sticky_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg    <= weight;
            f_reg    <= proto_factor;
            d_reg    <= data_value;
            v_reg    <= proto_value;
            last_reg <= last_column;
        end
        if (cmd.emit)
        begin
            dist_reg <= sum_reg;
            sat_reg  <= sticky_reg;
        end
        y_reg      <= y_next;
        p_reg      <= p_next;
        frac_reg   <= frac_next;
        lneg_reg   <= lneg_next;
        l2mag_reg  <= l2mag_next;
        prod_reg   <= prod_next;
        lnm_reg    <= lnm_next;
        a_reg      <= a_next;
        mag_reg    <= mag_next;
        ineg_reg   <= ineg_next;
        hiprod_reg <= hiprod_next;
        tmag_reg   <= tmag_next;
        hiovf_reg  <= hiovf_next;
    end

    assign stat.proto_zero = (v_reg == '0);
    assign stat.sticky     = sticky_reg;
    assign stat.last       = last_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign distance  = $signed(dist_reg);
    assign saturated = sat_reg;

endmodule

`default_nettype wire

### rtl/weighted_i_divergence_accumulate_top.sv
// A column term is computed before the next column can be taken; the log2 unit runs 28
//   squaring steps on the one shared 32x32 multiplier.
// A column met after saturation, or with a zero prototype, skips the term computation.
// The distance is loaded into the output register once the last column's term is summed
//   and the output register is free; the output register holds it while the next column is taken.
// Reset clears the sum, the saturation flag, the output valid and the controller.
`default_nettype none

module weighted_i_divergence_accumulate_top #(
    parameter int unsigned FRAC_BITS = wida_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    wida_col_if.sink          column,
    wida_res_if.source        result
);
    import wida_pkg::*;

    wida_cmd_t  cmd;
    wida_stat_t stat;
    logic       in_ready;

    assign column.ready = in_ready;

    wida_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (column.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    wida_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .weight       (column.weight),
        .proto_factor (column.proto_factor),
        .data_value   (column.data_value),
        .proto_value  (column.proto_value),
        .last_column  (column.last_column),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .distance     (result.distance),
        .saturated    (result.saturated)
    );

endmodule

`default_nettype wire
